// ===== sv/iprv_pkg.sv =====
// Package with shared types and constants for the IP range record validator.
`default_nettype none

package iprv_pkg;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam int unsigned OctetMax = 255;
  localparam logic [2:0] DotsNeeded = 3'd3;
  localparam logic [2:0] DotsMax    = 3'd7;

  // Field phases of a line: waiting for a field or inside one.
  typedef enum logic [7:0] {
    PhWaitLower = 8'b0000_0001,
    PhInLower   = 8'b0000_0010,
    PhWaitUpper = 8'b0000_0100,
    PhInUpper   = 8'b0000_1000,
    PhWaitZone  = 8'b0001_0000,
    PhInZone    = 8'b0010_0000,
    PhWaitArea  = 8'b0100_0000,
    PhInArea    = 8'b1000_0000
  } field_phase_e;

  typedef struct packed {
    logic         line_open;
    field_phase_e field_phase;
    logic [2:0]   dot_tally;
    logic [7:0]   octet_sum;
    logic         octet_over;
    logic         lower_good;
    logic         upper_good;
    logic         zero_seen;
  } scan_state_t;

  typedef struct packed {
    logic emit;
    logic line_done;
    logic line_valid;
    logic stream_end;
  } scan_result_t;

  localparam scan_state_t ScanClear = '{
    line_open:   1'b0,
    field_phase: PhWaitLower,
    dot_tally:   3'd0,
    octet_sum:   8'd0,
    octet_over:  1'b0,
    lower_good:  1'b0,
    upper_good:  1'b0,
    zero_seen:   1'b0
  };

endpackage

`default_nettype wire

// ===== sv/iprv_scan.sv =====
// Per-byte line parser: next scan state and line result for one text byte.
`default_nettype none

module iprv_scan (
  input  wire  iprv_pkg::scan_state_t  state_i,
  input  wire  logic [7:0]             text_byte_i,
  input  wire  logic                   end_of_buffer_i,
  output iprv_pkg::scan_state_t        state_o,
  output iprv_pkg::scan_result_t       result_o
);

  function automatic iprv_pkg::scan_state_t addr_clear(input iprv_pkg::scan_state_t s);
    iprv_pkg::scan_state_t r;
    r = s;
    r.dot_tally  = 3'd0;
    r.octet_sum  = 8'd0;
    r.octet_over = 1'b0;
    return r;
  endfunction

  function automatic iprv_pkg::scan_state_t addr_take(input iprv_pkg::scan_state_t s,
                                                      input logic [7:0] c);
    iprv_pkg::scan_state_t r;
    logic [11:0]           nxt;
    r   = s;
    nxt = {1'b0, s.octet_sum, 3'b000} + {3'b000, s.octet_sum, 1'b0}
          + {4'd0, c - iprv_pkg::CharZero};
    if (c == iprv_pkg::CharDot) begin
      if (s.dot_tally < iprv_pkg::DotsMax) begin
        r.dot_tally = s.dot_tally + 3'd1;
      end
      r.octet_sum = 8'd0;
    end else if (c >= iprv_pkg::CharZero && c <= iprv_pkg::CharNine) begin
      if (nxt > 12'(iprv_pkg::OctetMax)) begin
        r.octet_over = 1'b1;
        r.octet_sum  = 8'd0;
      end else begin
        r.octet_sum = nxt[7:0];
      end
    end
    return r;
  endfunction

  logic                  is_term;
  logic                  is_blank;
  logic                  addr_ok;
  iprv_pkg::scan_state_t work;
  iprv_pkg::scan_state_t upd;

  assign is_term  = (text_byte_i == iprv_pkg::CharCr) || (text_byte_i == iprv_pkg::CharLf);
  assign is_blank = (text_byte_i == iprv_pkg::CharSpace) || (text_byte_i == iprv_pkg::CharTab) ||
                    (text_byte_i == iprv_pkg::CharVt) || (text_byte_i == iprv_pkg::CharFf);

  always_comb begin
    work = state_i;
    if (!state_i.line_open) begin
      work = iprv_pkg::ScanClear;
      work.line_open = 1'b1;
    end
  end

  assign addr_ok = (work.dot_tally == iprv_pkg::DotsNeeded) && !work.octet_over;

  always_comb begin
    upd = work;
    if (!work.zero_seen) begin
      if (text_byte_i == iprv_pkg::CharNul) begin
        upd.zero_seen = 1'b1;
      end else begin
        unique case (work.field_phase)
          iprv_pkg::PhWaitLower: begin
            if (!is_blank) begin
              upd = addr_take(addr_clear(work), text_byte_i);
              upd.field_phase = iprv_pkg::PhInLower;
            end
          end
          iprv_pkg::PhWaitUpper: begin
            if (!is_blank) begin
              upd = addr_take(addr_clear(work), text_byte_i);
              upd.field_phase = iprv_pkg::PhInUpper;
            end
          end
          iprv_pkg::PhInLower: begin
            if (is_blank) begin
              upd.lower_good  = addr_ok;
              upd.field_phase = iprv_pkg::PhWaitUpper;
            end else begin
              upd = addr_take(work, text_byte_i);
            end
          end
          iprv_pkg::PhInUpper: begin
            if (is_blank) begin
              upd.upper_good  = addr_ok;
              upd.field_phase = iprv_pkg::PhWaitZone;
            end else begin
              upd = addr_take(work, text_byte_i);
            end
          end
          iprv_pkg::PhWaitZone: begin
            if (!is_blank) begin
              upd.field_phase = iprv_pkg::PhInZone;
            end
          end
          iprv_pkg::PhInZone: begin
            if (is_blank) begin
              upd.field_phase = iprv_pkg::PhWaitArea;
            end
          end
          iprv_pkg::PhWaitArea: begin
            if (!is_blank) begin
              upd.field_phase = iprv_pkg::PhInArea;
            end
          end
          default: begin
            upd = work;
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    if (is_term) begin
      if (state_i.line_open) begin
        result_o.line_done  = 1'b1;
        result_o.line_valid = (state_i.field_phase inside {iprv_pkg::PhInZone,
                                                           iprv_pkg::PhWaitArea,
                                                           iprv_pkg::PhInArea}) &&
                              state_i.lower_good && state_i.upper_good;
        state_o = iprv_pkg::ScanClear;
      end
    end else begin
      state_o = upd;
    end
    if (end_of_buffer_i) begin
      state_o = iprv_pkg::ScanClear;
    end
    result_o.stream_end = end_of_buffer_i;
    result_o.emit       = result_o.line_done || end_of_buffer_i;
  end

endmodule

`default_nettype wire

// ===== sv/iprv_count.sv =====
// Saturating valid record counter and its 32-bit saturated view.
`default_nettype none

module iprv_count #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire  logic [COUNT_WIDTH-1:0] count_i,
  input  wire  logic                   incr_i,
  input  wire  logic                   clear_i,
  output logic [COUNT_WIDTH-1:0]       count_o,
  output logic [COUNT_WIDTH-1:0]       next_o,
  output logic [31:0]                  view_o
);

  always_comb begin
    count_o = count_i;
    if (incr_i && (count_i != {COUNT_WIDTH{1'b1}})) begin
      count_o = count_i + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
    next_o = clear_i ? '0 : count_o;
  end

  if (COUNT_WIDTH > 32) begin : g_wide
    assign view_o = (|count_o[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : count_o[31:0];
  end else begin : g_narrow
    assign view_o = 32'(count_o);
  end

endmodule

`default_nettype wire

// ===== sv/ip_range_record_validator_core.sv =====
// Top level of the IP range record validator: handshakes, state and result registers.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: text_byte; tlast: end_of_buffer
//   m_axis   out        tdata: line_done, line_valid, any_valid, valid_count; tlast: stream_end
//
// The scan state is updated at the accept edge, and a result, if any, is captured
// in the output register at that same edge.
// One byte per cycle is sustained while the output side takes results.
// A held result blocks further bytes only while m_axis_tready is low.
// Reset clears the scan state, the record count and the output valid.
`default_nettype none

module ip_range_record_validator_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire  logic        s_axis_tlast,   // end_of_buffer
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [0] line_done, [1] line_valid, [2] any_valid,
                                            // [34:3] valid_count, [39:35] zero
  output logic              m_axis_tlast    // stream_end
);

  iprv_pkg::scan_state_t  state_q;
  iprv_pkg::scan_state_t  state_d;
  iprv_pkg::scan_result_t res;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [COUNT_WIDTH-1:0] count_d;
  logic [COUNT_WIDTH-1:0] count_now;
  logic [31:0]            count_view;
  logic                   accept;
  logic                   out_valid_q;
  logic [39:0]            out_data_q;
  logic                   out_last_q;

  iprv_scan u_scan (
    .state_i         (state_q),
    .text_byte_i     (s_axis_tdata),
    .end_of_buffer_i (s_axis_tlast),
    .state_o         (state_d),
    .result_o        (res)
  );

  iprv_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .count_i (count_q),
    .incr_i  (res.line_valid),
    .clear_i (res.stream_end),
    .count_o (count_now),
    .next_o  (count_d),
    .view_o  (count_view)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iprv_pkg::ScanClear;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (accept && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.emit) begin
      out_data_q <= {5'd0, count_view, (|count_now), res.line_valid, res.line_done};
      out_last_q <= res.stream_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
